FILE: src/atrlc_pkg.sv
package atrlc_pkg;

  localparam int unsigned PrefixDepth = 6;
  localparam int unsigned LineFillW   = 8;
  localparam int unsigned ReplyFillW  = 10;
  localparam int unsigned TallyW      = 16;

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChPrompt = 8'h3E;

  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  typedef logic [7:0] char_t;
  typedef char_t [PrefixDepth-1:0] prefix_t;

  localparam prefix_t PatAt    = {8'h00, 8'h00, 8'h00, 8'h00, "T", "A"};
  localparam prefix_t PatAtGmr = {"R", "M", "G", "+", "T", "A"};
  localparam prefix_t PatOk    = {8'h00, 8'h00, 8'h00, 8'h00, "K", "O"};
  localparam prefix_t PatError = {8'h00, "R", "O", "R", "R", "E"};
  localparam prefix_t PatFail  = {8'h00, 8'h00, "L", "I", "A", "F"};

  typedef enum logic [1:0] {
    FINAL_NONE  = 2'd0,
    FINAL_OK    = 2'd1,
    FINAL_ERROR = 2'd2
  } final_e;

  typedef enum logic {
    OP_FEED   = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    op_e   op;
    char_t data;
  } item_t;

  typedef struct packed {
    logic [TallyW-1:0] unsol_cnt;
    logic [TallyW-1:0] prompt_cnt;
    logic [TallyW-1:0] echo_cnt;
    logic              overflow;
    logic              complete;
    final_e            final_status;
  } res_t;

  function automatic logic line_is(prefix_t prefix, logic [LineFillW-1:0] fill,
                                   prefix_t pat, logic [LineFillW-1:0] len);
    logic hit;
    hit = (fill == len);
    for (int i = 0; i < PrefixDepth; i++) begin
      if ((LineFillW'(i) < len) && (prefix[i] != pat[i])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  function automatic logic [TallyW-1:0] sat_inc(logic [TallyW-1:0] v);
    return (v == TallyMax) ? v : v + TallyW'(1);
  endfunction

endpackage

FILE: src/atrlc_core.sv
module atrlc_core #(
  parameter int unsigned LINE_CAPACITY  = 128,
  parameter int unsigned REPLY_CAPACITY = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  atrlc_pkg::item_t item_i,
  output atrlc_pkg::res_t  res_o
);
  import atrlc_pkg::*;

  localparam logic [LineFillW-1:0]  LineCap  = LineFillW'(LINE_CAPACITY);
  localparam logic [ReplyFillW-1:0] ReplyCap = ReplyFillW'(REPLY_CAPACITY);

  prefix_t               prefix_q, prefix_d;
  logic [LineFillW-1:0]  line_fill_q, line_fill_d;
  logic [ReplyFillW-1:0] reply_fill_q, reply_fill_d;
  logic                  ovf_q, ovf_d;
  logic                  last_lf_q, last_lf_d;
  final_e                final_q, final_d;
  logic [TallyW-1:0]     echo_q, echo_d;
  logic [TallyW-1:0]     prompt_q, prompt_d;
  logic [TallyW-1:0]     unsol_q, unsol_d;

  logic feed, is_term, do_close;

  always_comb begin
    prefix_d     = prefix_q;
    line_fill_d  = line_fill_q;
    reply_fill_d = reply_fill_q;
    ovf_d        = ovf_q;
    last_lf_d    = last_lf_q;
    final_d      = final_q;
    echo_d       = echo_q;
    prompt_d     = prompt_q;
    unsol_d      = unsol_q;

    feed     = (item_i.op == OP_FEED);
    is_term  = (item_i.data == ChCr) || (item_i.data == ChLf);
    do_close = !feed || is_term;

    if (feed) begin
      if (reply_fill_q < ReplyCap) begin
        reply_fill_d = reply_fill_q + ReplyFillW'(1);
      end else begin
        ovf_d = 1'b1;
      end
      last_lf_d = (item_i.data == ChLf);
      if (item_i.data == ChPrompt) begin
        prompt_d = sat_inc(prompt_q);
      end
      if (!is_term) begin
        if (line_fill_q < LineCap) begin
          if (line_fill_q < LineFillW'(PrefixDepth)) begin
            prefix_d[line_fill_q[2:0]] = item_i.data;
          end
          line_fill_d = line_fill_q + LineFillW'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
    end

    if (do_close && (line_fill_q != '0)) begin
      line_fill_d = '0;
      if (line_is(prefix_q, line_fill_q, PatAt, LineFillW'(2)) ||
          line_is(prefix_q, line_fill_q, PatAtGmr, LineFillW'(6))) begin
        echo_d = sat_inc(echo_q);
      end else if (prefix_q[0] == ChPrompt) begin
        final_d = final_q;
      end else if (line_is(prefix_q, line_fill_q, PatOk, LineFillW'(2))) begin
        final_d = FINAL_OK;
      end else if (line_is(prefix_q, line_fill_q, PatError, LineFillW'(5)) ||
                   line_is(prefix_q, line_fill_q, PatFail, LineFillW'(4))) begin
        final_d = FINAL_ERROR;
      end else begin
        unsol_d = sat_inc(unsol_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_fill_q  <= '0;
      reply_fill_q <= '0;
      ovf_q        <= 1'b0;
      last_lf_q    <= 1'b0;
      final_q      <= FINAL_NONE;
      echo_q       <= '0;
      prompt_q     <= '0;
      unsol_q      <= '0;
    end else if (en_i) begin
      line_fill_q  <= line_fill_d;
      reply_fill_q <= reply_fill_d;
      ovf_q        <= ovf_d;
      last_lf_q    <= last_lf_d;
      final_q      <= final_d;
      echo_q       <= echo_d;
      prompt_q     <= prompt_d;
      unsol_q      <= unsol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prefix_q <= prefix_d;
    end
  end

  always_comb begin
    res_o.final_status = final_d;
    res_o.complete     = (final_d != FINAL_NONE) && last_lf_d;
    res_o.overflow     = ovf_d;
    res_o.echo_cnt     = echo_d;
    res_o.prompt_cnt   = prompt_d;
    res_o.unsol_cnt    = unsol_d;
  end

endmodule

FILE: src/atrlc_outreg.sv
module atrlc_outreg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  atrlc_pkg::res_t res_i,
  input  logic            ready_i,
  output logic            valid_o,
  output atrlc_pkg::res_t res_o
);
  import atrlc_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: src/at_response_line_classifier_top.sv
// Classifies modem reply bytes into lines and reports a status snapshot per item. Each input
// item (a fed byte, or a finish that closes the pending line) yields exactly one result, which
// is held in the input register, then processed and loaded into the output register, from
// which it is offered. One item is taken every cycle while the result side does not stall:
// an input register feeds a combinational state update and classification against the six
// stored prefix bytes, whose outcome lands in an output register. Backpressure on the result
// side stalls the input only once both registers hold an item.
module at_response_line_classifier_top #(
  parameter int unsigned LINE_CAPACITY  = 128,
  parameter int unsigned REPLY_CAPACITY = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // [1:0] final_status, [2] complete, [3] overflow,
                                     // [19:4] echo count, [35:20] prompt count,
                                     // [51:36] unsolicited line count, [55:52] zero
);
  import atrlc_pkg::*;

  logic  in_vld_q, in_vld_d;
  item_t in_item_q;
  logic  advance;
  res_t  core_res, out_res;

  assign advance       = in_vld_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.op   <= op_e'(s_axis_tuser[0]);
      in_item_q.data <= s_axis_tdata;
    end
  end

  atrlc_core #(
    .LINE_CAPACITY  (LINE_CAPACITY),
    .REPLY_CAPACITY (REPLY_CAPACITY)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_item_q),
    .res_o  (core_res)
  );

  atrlc_outreg u_outreg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (core_res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {4'b0000, out_res};

endmodule

FILE: src/atrlc_port_chk.sv
module atrlc_port_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  import atrlc_pkg::*;

  logic              seen_q;
  logic              last_ovf_q;
  logic [TallyW-1:0] last_prompt_q;
  logic              out_acc;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      last_ovf_q    <= 1'b0;
      last_prompt_q <= '0;
    end else if (out_acc) begin
      seen_q        <= 1'b1;
      last_ovf_q    <= m_axis_tdata[3];
      last_prompt_q <= m_axis_tdata[35:20];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output is empty");

  a_complete_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] != 2'd0)
    else $error("complete flagged without a final status");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && last_ovf_q |-> m_axis_tdata[3])
    else $error("overflow flag dropped");

  a_prompt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q |-> (m_axis_tdata[35:20] == last_prompt_q) ||
                          (m_axis_tdata[35:20] == last_prompt_q + TallyW'(1)))
    else $error("prompt count stepped by more than one item");

endmodule

bind at_response_line_classifier_top atrlc_port_chk u_port_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
